### sv/hcbd_pkg.sv
// Shared types, constants and helpers for the HTTP chunked body decoder.
package hcbd_pkg;

  localparam int SIZE_BITS  = 32;
  localparam int LINE_LIMIT = 31;
  localparam int LEN_BITS   = $clog2(LINE_LIMIT + 1);

  localparam logic [SIZE_BITS-1:0] SIZE_MAX = {SIZE_BITS{1'b1}};

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [4:0] DIGIT_NONE = 5'd16;
  localparam logic [1:0] TRAIL_BYTES = 2'd2;

  typedef enum logic [2:0] {
    PH_WS,
    PH_SIGN,
    PH_ZERO,
    PH_X,
    PH_DIGITS,
    PH_DONE,
    PH_DATA,
    PH_TRAIL
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_DONE    = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NO_CRLF   = 2'd0,
    ERR_LONG_LINE = 2'd1,
    ERR_BAD_SIZE  = 2'd2,
    ERR_TRUNCATED = 2'd3
  } err_t;

  // Size line parser state; the chunk counter lives here as well.
  typedef struct packed {
    phase_t               phase;
    logic [LEN_BITS-1:0]  line_len;
    logic [SIZE_BITS-1:0] remaining;
    logic                 negative;
    logic                 digit_seen;
  } line_t;

  typedef struct packed {
    line_t      line;
    logic       pending_cr;
    logic       finished;
    logic [1:0] trail_left;
  } state_t;

  typedef struct packed {
    logic       valid;
    kind_t      kind;
    logic [7:0] payload;
    err_t       code;
  } result_t;

  localparam line_t LINE_RESET = '{
    phase:      PH_WS,
    line_len:   '0,
    remaining:  '0,
    negative:   1'b0,
    digit_seen: 1'b0
  };

  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] d;
    d = DIGIT_NONE;
    if (c >= "0" && c <= "9") d = 5'(c - 8'("0"));
    else if (c >= "a" && c <= "f") d = 5'(c - 8'("a") + 8'd10);
    else if (c >= "A" && c <= "F") d = 5'(c - 8'("A") + 8'd10);
    return d;
  endfunction

endpackage

### sv/hcbd_line_parse.sv
// Applies one size line character to the hex size parser state.
module hcbd_line_parse (
  input  hcbd_pkg::line_t line_in,
  input  logic [7:0]      char_in,
  output hcbd_pkg::line_t line_out
);
  import hcbd_pkg::*;

  logic [4:0] d;
  logic       is_ws;
  logic       is_hex;
  logic       saturate;
  logic       take_digit;

  assign d        = hex_val(char_in);
  assign is_hex   = (d != DIGIT_NONE);
  assign is_ws    = (char_in == " ") || (char_in inside {[8'd9:8'd13]});
  // Shifting in another digit overflows once any of the top four bits is set.
  assign saturate = (line_in.remaining[SIZE_BITS-1 -: 4] != 4'd0);

  always_comb begin
    line_out   = line_in;
    take_digit = 1'b0;
    if (line_in.line_len < LEN_BITS'(LINE_LIMIT)) begin
      line_out.line_len = line_in.line_len + LEN_BITS'(1);
    end
    case (line_in.phase)
      PH_WS, PH_SIGN: begin
        if (line_in.phase == PH_WS && is_ws) begin
          line_out.phase = PH_WS;
        end else if (line_in.phase == PH_WS && (char_in == "+" || char_in == "-")) begin
          line_out.negative = (char_in == "-");
          line_out.phase    = PH_SIGN;
        end else if (char_in == "0") begin
          line_out.digit_seen = 1'b1;
          line_out.phase      = PH_ZERO;
        end else if (is_hex) begin
          take_digit = 1'b1;
        end else begin
          line_out.phase = PH_DONE;
        end
      end
      PH_ZERO: begin
        if (char_in == "x" || char_in == "X") begin
          line_out.phase = PH_X;
        end else if (is_hex) begin
          take_digit = 1'b1;
        end else begin
          line_out.phase = PH_DONE;
        end
      end
      PH_X, PH_DIGITS: begin
        if (is_hex) begin
          take_digit = 1'b1;
        end else begin
          line_out.phase = PH_DONE;
        end
      end
      default: begin
        line_out.phase = line_in.phase;
      end
    endcase
    if (take_digit) begin
      line_out.digit_seen = 1'b1;
      line_out.phase      = PH_DIGITS;
      line_out.remaining  = saturate ? SIZE_MAX
                                     : {line_in.remaining[SIZE_BITS-5:0], d[3:0]};
    end
  end

endmodule

### sv/hcbd_step.sv
// Next decoder state and optional result for one body byte.
module hcbd_step (
  input  hcbd_pkg::state_t  state,
  input  logic [7:0]        body_byte,
  input  logic              first_byte,
  input  logic              last_byte,
  output hcbd_pkg::state_t  state_next,
  output hcbd_pkg::result_t result
);
  import hcbd_pkg::*;

  state_t               s;
  line_t                cr_line;
  line_t                byte_line_in;
  line_t                byte_line;
  logic [SIZE_BITS-1:0] rem_dec;
  logic [1:0]           trail_dec;

  // A held CR that is not followed by LF counts as a line character.
  hcbd_line_parse u_parse_cr (
    .line_in  (s.line),
    .char_in  (CHAR_CR),
    .line_out (cr_line)
  );

  assign byte_line_in = s.pending_cr ? cr_line : s.line;

  hcbd_line_parse u_parse_byte (
    .line_in  (byte_line_in),
    .char_in  (body_byte),
    .line_out (byte_line)
  );

  assign rem_dec   = s.line.remaining - SIZE_BITS'(1);
  assign trail_dec = s.trail_left - 2'd1;

  always_comb begin
    s = state;
    if (first_byte) begin
      s.line       = LINE_RESET;
      s.pending_cr = 1'b0;
      s.trail_left = 2'd0;
      s.finished   = 1'b0;
    end
  end

  always_comb begin
    state_next = s;
    result     = '{valid: 1'b0, kind: KIND_PAYLOAD, payload: 8'd0, code: ERR_NO_CRLF};
    if (s.finished) begin
      state_next = s;
    end else if (s.line.phase == PH_DATA) begin
      state_next.line.remaining = rem_dec;
      if (rem_dec == '0) begin
        state_next.line.phase = PH_TRAIL;
        state_next.trail_left = TRAIL_BYTES;
      end
      if (last_byte) begin
        result = '{valid: 1'b1, kind: KIND_ERROR, payload: 8'd0, code: ERR_TRUNCATED};
      end else begin
        result = '{valid: 1'b1, kind: KIND_PAYLOAD, payload: body_byte, code: ERR_NO_CRLF};
      end
    end else if (s.line.phase == PH_TRAIL) begin
      state_next.trail_left = trail_dec;
      if (trail_dec == 2'd0) begin
        state_next.line       = LINE_RESET;
        state_next.pending_cr = 1'b0;
        if (last_byte) begin
          result = '{valid: 1'b1, kind: KIND_DONE, payload: 8'd0, code: ERR_NO_CRLF};
        end
      end else if (last_byte) begin
        result = '{valid: 1'b1, kind: KIND_ERROR, payload: 8'd0, code: ERR_TRUNCATED};
      end
    end else if (s.pending_cr && body_byte == CHAR_LF) begin
      // End of the size line: decide on the chunk size.
      state_next.pending_cr = 1'b0;
      if (s.line.line_len >= LEN_BITS'(LINE_LIMIT)) begin
        result = '{valid: 1'b1, kind: KIND_ERROR, payload: 8'd0, code: ERR_LONG_LINE};
      end else if (!s.line.digit_seen) begin
        result = '{valid: 1'b1, kind: KIND_ERROR, payload: 8'd0, code: ERR_BAD_SIZE};
      end else if (s.line.remaining != '0 && s.line.negative) begin
        result = '{valid: 1'b1, kind: KIND_ERROR, payload: 8'd0, code: ERR_BAD_SIZE};
      end else if (s.line.remaining == '0) begin
        result = '{valid: 1'b1, kind: KIND_DONE, payload: 8'd0, code: ERR_NO_CRLF};
      end else begin
        state_next.line.phase = PH_DATA;
        if (last_byte) begin
          result = '{valid: 1'b1, kind: KIND_ERROR, payload: 8'd0, code: ERR_TRUNCATED};
        end
      end
    end else begin
      state_next.pending_cr = (body_byte == CHAR_CR);
      state_next.line       = (body_byte == CHAR_CR) ? byte_line_in : byte_line;
      if (last_byte) begin
        result = '{valid: 1'b1, kind: KIND_ERROR, payload: 8'd0, code: ERR_NO_CRLF};
      end
    end
    if (result.valid && result.kind != KIND_PAYLOAD) begin
      state_next.finished = 1'b1;
    end
  end

endmodule

### sv/http_chunked_body_decoder.sv
// Top level of the HTTP chunked body decoder: request registers, state and result register.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+------------------------------------------
//   in      | input     | in_valid / in_stall | body_byte, first_byte, last_byte
//   out     | output    | out_valid/out_stall | result_kind, payload_byte, error_code
//
// One body byte is taken per cycle while in_stall is low; a request is held in the input
// register, is decoded by the step logic and lands in the result register.
// Unstalled throughput is one byte per cycle, set by the single decode step in between.
// rst (synchronous) empties both registers and leaves the decoder idle until a first byte.
// in_stall rises only while the input register holds a request and the result register
// is full and stalled; a byte that gives no result still needs that slot to move on.
module http_chunked_body_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] body_byte,
  input  logic       first_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] result_kind,
  output logic [7:0] payload_byte,
  output logic [1:0] error_code
);
  import hcbd_pkg::*;

  logic       in_q_valid;
  logic [7:0] in_q_byte;
  logic       in_q_first;
  logic       in_q_last;
  state_t     state;
  state_t     state_next;
  result_t    res;
  result_t    out_q;
  logic       out_free;
  logic       advance;
  logic       accept;

  assign out_free = !out_q.valid || !out_stall;
  assign advance  = in_q_valid && out_free;
  assign in_stall = in_q_valid && !out_free;
  assign accept   = in_valid && !in_stall;

  hcbd_step u_step (
    .state      (state),
    .body_byte  (in_q_byte),
    .first_byte (in_q_first),
    .last_byte  (in_q_last),
    .state_next (state_next),
    .result     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (accept) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_q_byte  <= body_byte;
      in_q_first <= first_byte;
      in_q_last  <= last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{line: LINE_RESET, pending_cr: 1'b0, finished: 1'b1, trail_left: 2'd0};
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_q.valid <= 1'b0;
    end else if (out_free) begin
      out_q.valid <= advance && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && out_free) begin
      out_q.kind    <= res.kind;
      out_q.payload <= res.payload;
      out_q.code    <= res.code;
    end
  end

  assign out_valid    = out_q.valid;
  assign result_kind  = out_q.kind;
  assign payload_byte = out_q.payload;
  assign error_code   = out_q.code;

  // A status result always leaves the decoder idle.
  a_status_ends: assert property (@(posedge clk) disable iff (rst)
    (advance && res.valid && res.kind != KIND_PAYLOAD) |=> state.finished)
    else $error("decoder not idle after status result");

  // The input side stalls only behind a full, stalled result register.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (in_q_valid && out_q.valid && out_stall))
    else $error("input stalled without a blocked result");

  // Chunk data phase never runs with an exhausted counter.
  a_data_count: assert property (@(posedge clk) disable iff (rst)
    (!state.finished && state.line.phase == PH_DATA) |-> (state.line.remaining != '0))
    else $error("data phase with zero bytes left");

  // The trailer phase always has bytes left to skip.
  a_trail_count: assert property (@(posedge clk) disable iff (rst)
    (!state.finished && state.line.phase == PH_TRAIL) |-> (state.trail_left != 2'd0))
    else $error("trailer phase with nothing left to skip");

endmodule
